// File: rtl/lfd_pkg.sv
// Shared types and constants of the LEB128 field decoder.
`default_nettype none

package lfd_pkg;

  // Field kind codes, as carried in req_type and field_kind.
  localparam logic [3:0] KIND_U1     = 4'd0;
  localparam logic [3:0] KIND_U7     = 4'd1;
  localparam logic [3:0] KIND_S7     = 4'd2;
  localparam logic [3:0] KIND_U32LEB = 4'd3;
  localparam logic [3:0] KIND_S32LEB = 4'd4;
  localparam logic [3:0] KIND_S64LEB = 4'd5;
  localparam logic [3:0] KIND_U32LE  = 4'd6;
  localparam logic [3:0] KIND_U64LE  = 4'd7;
  localparam logic [3:0] KIND_OPCODE = 4'd8;
  localparam logic [3:0] KIND_LAST   = KIND_OPCODE;

  // Byte limits of the multi-byte kinds.
  localparam logic [3:0] LEB32_LIMIT = 4'd5;
  localparam logic [3:0] LEB64_LIMIT = 4'd10;
  localparam logic [3:0] LE32_BYTES  = 4'd4;
  localparam logic [3:0] LE64_BYTES  = 4'd8;

  typedef struct packed {
    logic [3:0] req_type;
    logic [7:0] byte_in;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  field_kind;
    logic [3:0]  byte_count;
    logic        overlong;
  } rsp_t;

  typedef struct packed {
    logic [63:0] accumulator;
    logic [3:0]  bytes_taken;
    logic [3:0]  active_kind;
    logic        in_field;
  } dec_state_t;

endpackage

`default_nettype wire

// File: rtl/leb128_field_decoder.sv
// Top level of the byte-serial LEB128 / fixed-width field decoder.
`default_nettype none

// Byte-serial field decoder. Each req transfer carries one stream byte and,
// on the first byte of a field, the field kind in req_type (ignored while a
// field is in progress; a first byte with an unknown kind is dropped). LEB128
// kinds gather 7-bit groups until a byte with bit 7 clear or the byte limit
// (5 for 32-bit kinds, 10 for s64), overlong if bit 7 is set there. Little-endian
// kinds take exactly 4 or 8 bytes; the single-byte kinds finish at once. One rsp
// transfer carries each completed field: 64-bit value (signed kinds
// sign-extended), kind, byte count and overlong. Throughput is one byte per
// clock while req_stall is low. A byte passes one input register stage, then
// shift-and-OR into the field accumulator and the result register. The input
// stage lets a new byte in while a result is stalled, as long as the held
// byte does not itself complete a field.
module leb128_field_decoder import lfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // Input stage.
  logic       hold_valid;
  req_t       hold;

  // Field state.
  dec_state_t state;
  dec_state_t state_next;
  logic       step_emit;
  rsp_t       step_rsp;
  logic       hold_go;

  lfd_step u_step (
    .cur    (state),
    .item   (hold),
    .nxt    (state_next),
    .emit   (step_emit),
    .result (step_rsp)
  );

  // Advance the held byte unless it completes a field while the result
  // register is still full and stalled.
  assign hold_go   = !step_emit || !rsp_valid || !rsp_stall;
  assign req_stall = hold_valid && !hold_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      hold_valid <= 1'b1;
    end else if (hold_go) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (hold_valid && hold_go) begin
      state <= state_next;
    end
  end

  // Result register: load a completed field, drop it once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (hold_valid && hold_go && step_emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && hold_go && step_emit) begin
      rsp <= step_rsp;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lfd_step.sv
// Combinational decode of one byte: next field state and completed result.
`default_nettype none

module lfd_step import lfd_pkg::*; (
  input  wire dec_state_t cur,
  input  wire req_t       item,
  output dec_state_t      nxt,
  output logic            emit,
  output rsp_t            result
);

  logic [3:0]  kind;
  logic [63:0] acc_base;
  logic [3:0]  cnt_base;
  logic [3:0]  limit;
  logic [3:0]  cnt;
  logic [3:0]  cnt_inc;
  logic [6:0]  sh7;
  logic [6:0]  pos;
  logic [5:0]  sh8;
  logic [63:0] leb_acc;
  logic [63:0] le_acc;
  logic [63:0] fill;
  logic [63:0] v;
  logic [7:0]  b;
  logic        ignore;

  always_comb begin
    b        = item.byte_in;
    kind     = cur.in_field ? cur.active_kind : item.req_type;
    ignore   = !cur.in_field && (item.req_type > KIND_LAST);
    acc_base = cur.in_field ? cur.accumulator : 64'd0;
    cnt_base = cur.in_field ? cur.bytes_taken : 4'd0;

    case (kind)
      KIND_S64LEB: limit = LEB64_LIMIT;
      KIND_U32LEB,
      KIND_S32LEB: limit = LEB32_LIMIT;
      KIND_U32LE:  limit = LE32_BYTES;
      default:     limit = LE64_BYTES;
    endcase

    // Wrap a count that has reached or run past its limit.
    cnt     = (cnt_base >= limit) ? 4'd0 : cnt_base;
    cnt_inc = cnt + 4'd1;
    sh7     = {cnt, 3'b000} - {3'b000, cnt};
    pos     = sh7 + 7'd7;
    sh8     = {cnt[2:0], 3'b000};
    leb_acc = acc_base | ({57'd0, b[6:0]} << sh7[5:0]);
    le_acc  = acc_base | ({56'd0, b} << sh8);
    fill    = (pos < 7'd64 && b[6]) ? (~64'd0 << pos[5:0]) : 64'd0;

    nxt               = cur;
    emit              = 1'b0;
    result.value      = 64'd0;
    result.field_kind = kind;
    result.byte_count = 4'd1;
    result.overlong   = 1'b0;
    v                 = 64'd0;

    if (!ignore) begin
      nxt.active_kind = kind;
      nxt.accumulator = 64'd0;
      nxt.bytes_taken = 4'd0;
      nxt.in_field    = 1'b0;
      case (kind)
        KIND_U1: begin
          emit         = 1'b1;
          result.value = {63'd0, b[0]};
        end
        KIND_U7: begin
          emit         = 1'b1;
          result.value = {57'd0, b[6:0]};
        end
        KIND_S7: begin
          emit         = 1'b1;
          result.value = {{57{b[6]}}, b[6:0]};
        end
        KIND_U32LEB, KIND_S32LEB, KIND_S64LEB: begin
          if (b[7] && cnt_inc < limit) begin
            nxt.in_field    = 1'b1;
            nxt.accumulator = leb_acc;
            nxt.bytes_taken = cnt_inc;
          end else begin
            emit = 1'b1;
            case (kind)
              KIND_U32LEB: v = {32'd0, leb_acc[31:0]};
              KIND_S32LEB: begin
                v = leb_acc | fill;
                v = {{32{v[31]}}, v[31:0]};
              end
              default:     v = leb_acc | fill;
            endcase
            result.value      = v;
            result.byte_count = cnt_inc;
            result.overlong   = b[7];
          end
        end
        KIND_U32LE, KIND_U64LE: begin
          if (cnt_inc < limit) begin
            nxt.in_field    = 1'b1;
            nxt.accumulator = le_acc;
            nxt.bytes_taken = cnt_inc;
          end else begin
            emit              = 1'b1;
            result.value      = le_acc;
            result.byte_count = cnt_inc;
          end
        end
        default: begin
          emit         = 1'b1;
          result.value = {56'd0, b};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the byte-serial LEB128 / fixed-width field decoder.
`default_nettype none

module tb_top;
  import lfd_pkg::*;

  // Cycles to wait after the last expected result. This covers the
  // input and result registers plus margin for bytes that complete no field.
  localparam int DRAIN_PAD   = 8;
  localparam int DRAIN_LIMIT = 50000;

  // Receiver behavior while it is not in a forced hold-off.
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  leb128_field_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Mirror of the decoder's field state. It advances once per accepted transfer.
  logic [63:0] field_acc   = '0;
  logic [3:0]  field_bytes = '0;
  logic [3:0]  field_kind  = '0;
  bit          field_open  = 1'b0;

  rsp_t pending_fields[$];
  int   errors     = 0;
  int   bytes_sent = 0;

  // Sender pacing. Each burst is preceded by a short idle gap when gaps are enabled.
  bit gaps_on    = 1'b0;
  int burst_left = 0;

  // Receiver pacing. The hold-off is counted down inside the receiver process.
  rx_mode_e rx_mode    = RX_FREE;
  int       hold_start = 0;
  int       hold_left  = 0;
  int       run_left   = 0;
  bit       run_stall  = 1'b0;

  // Advance the mirrored field state by one byte. Return 1 and fill 'done'
  // when that byte completes a field.
  function automatic bit decode_byte(input req_t r, output rsp_t done);
    logic [7:0]  b;
    logic [63:0] v;
    logic [3:0]  limit;
    int unsigned pos;
    b = r.byte_in;
    done = '0;
    if (!field_open) begin
      // An unknown kind on a field's first byte is dropped and leaves no trace.
      if (r.req_type > KIND_LAST) return 1'b0;
      field_kind  = r.req_type;
      field_acc   = '0;
      field_bytes = '0;
    end
    done.field_kind = field_kind;
    done.byte_count = 4'd1;
    case (field_kind)
      KIND_U1: done.value = {63'd0, b[0]};
      KIND_U7: done.value = {57'd0, b[6:0]};
      KIND_S7: done.value = {{57{b[6]}}, b[6:0]};
      KIND_U32LEB, KIND_S32LEB, KIND_S64LEB: begin
        limit = (field_kind == KIND_S64LEB) ? LEB64_LIMIT : LEB32_LIMIT;
        field_acc = field_acc | ({57'd0, b[6:0]} << (7 * field_bytes));
        field_bytes++;
        if (b[7] && field_bytes < limit) begin
          field_open = 1'b1;
          return 1'b0;
        end
        pos = 7 * field_bytes;
        v = field_acc;
        if (field_kind == KIND_U32LEB) begin
          v[63:32] = '0;
        end else begin
          // Sign-fill from bit 6 of the last group, then narrow s32 to 32 bits.
          if (pos < 64 && b[6]) v = v | ({64{1'b1}} << pos);
          if (field_kind == KIND_S32LEB) v[63:32] = {32{v[31]}};
        end
        done.value      = v;
        done.byte_count = field_bytes;
        done.overlong   = b[7];
      end
      KIND_U32LE, KIND_U64LE: begin
        limit = (field_kind == KIND_U32LE) ? LE32_BYTES : LE64_BYTES;
        field_acc = field_acc | ({56'd0, b} << (8 * field_bytes));
        field_bytes++;
        if (field_bytes < limit) begin
          field_open = 1'b1;
          return 1'b0;
        end
        done.value      = field_acc;
        done.byte_count = field_bytes;
      end
      default: done.value = {56'd0, b};
    endcase
    field_open  = 1'b0;
    field_acc   = '0;
    field_bytes = '0;
    return 1'b1;
  endfunction

  // Hold the request side idle. Scramble the payload while valid is low.
  task automatic idle_sender(input int n);
    req_valid = 1'b0;
    req = req_t'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // Offer one byte and wait for its transfer, then record what it should produce.
  // Leave valid high so that back-to-back bytes follow without a gap.
  task automatic send_byte(input logic [3:0] kind, input logic [7:0] data);
    req_t r;
    rsp_t done;
    if (burst_left == 0) begin
      if (gaps_on) idle_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    r.req_type = kind;
    r.byte_in  = data;
    req_valid  = 1'b1;
    req        = r;
    do @(posedge clk); while (req_stall);
    if (decode_byte(r, done)) pending_fields.push_back(done);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send one field of the given kind with random content, at times overlong. Tag
  // continuation bytes with random kinds, because the decoder must ignore them.
  task automatic send_field(input logic [3:0] kind);
    int         len;
    logic [3:0] limit;
    logic [7:0] b;
    bit         over;
    case (kind)
      KIND_U32LEB, KIND_S32LEB, KIND_S64LEB: begin
        limit = (kind == KIND_S64LEB) ? LEB64_LIMIT : LEB32_LIMIT;
        over  = ($urandom_range(0, 9) == 0);
        len   = over ? int'(limit) : $urandom_range(1, limit);
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          b[7] = over || (i < len - 1);
          send_byte((i == 0) ? kind : 4'($urandom_range(0, 15)), b);
        end
      end
      KIND_U32LE, KIND_U64LE: begin
        len = (kind == KIND_U32LE) ? int'(LE32_BYTES) : int'(LE64_BYTES);
        for (int i = 0; i < len; i++)
          send_byte((i == 0) ? kind : 4'($urandom_range(0, 15)), 8'($urandom));
      end
      default: send_byte(kind, 8'($urandom));
    endcase
  endtask

  // Feed random bytes until any open field completes, so the next test starts clean.
  task automatic close_field();
    while (field_open) send_byte(KIND_OPCODE, 8'($urandom));
  endtask

  // Pause the sender until every pending field has arrived, then let the pipeline settle.
  task automatic wait_idle();
    int n;
    n = 0;
    req_valid = 1'b0;
    while (pending_fields.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (pending_fields.size() != 0) begin
      $error("%0d expected fields never arrived", pending_fields.size());
      errors++;
      pending_fields.delete();
    end
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  // Send at least n useful bytes: mostly whole fields, some single noise bytes.
  task automatic send_mixed(input int n);
    int target;
    logic [3:0] k;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        send_field(4'($urandom_range(0, KIND_LAST)));
      end else begin
        // A noise byte may open a field that the next items continue.
        k = 4'($urandom_range(0, 15));
        send_byte(k, 8'($urandom));
        if (k > KIND_LAST && !field_open) bytes_sent--;
      end
    end
    close_field();
  endtask

  // Receiver. The response stall is changed only at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_start != 0 || hold_left > 0) begin
      if (hold_start != 0) begin
        hold_left  = hold_start;
        hold_start = 0;
      end
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_FREE:   rsp_stall <= 1'b0;
        RX_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 40);
        RX_BURSTY: begin
          // Alternate stall and free runs of random length.
          if (run_left == 0) begin
            run_stall = !run_stall;
            run_left  = $urandom_range(1, 8);
          end
          run_left--;
          rsp_stall <= run_stall;
        end
        default:   rsp_stall <= 1'b0;
      endcase
    end
  end

  // Check each response transfer against the oldest pending field.
  rsp_t want;
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_fields.size() == 0) begin
        $error("unexpected field: value %h kind %0d count %0d overlong %0b",
               rsp.value, rsp.field_kind, rsp.byte_count, rsp.overlong);
        errors++;
      end else begin
        want = pending_fields.pop_front();
        if (rsp.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, rsp.value);
          errors++;
        end
        if (rsp.field_kind !== want.field_kind) begin
          $error("field_kind: expected %0d, got %0d", want.field_kind, rsp.field_kind);
          errors++;
        end
        if (rsp.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, rsp.byte_count);
          errors++;
        end
        if (rsp.overlong !== want.overlong) begin
          $error("overlong: expected %0b, got %0b", want.overlong, rsp.overlong);
          errors++;
        end
      end
    end
  end

  // Single-byte kinds at their extremes, including the bit 7 that u7 and s7 ignore.
  task automatic test_single_byte_kinds();
    send_byte(KIND_U1, 8'hFF);
    send_byte(KIND_U7, 8'h80);
    send_byte(KIND_S7, 8'hC0);
    send_byte(KIND_S7, 8'h3F);
    send_byte(KIND_OPCODE, 8'hFF);
    send_byte(KIND_OPCODE, 8'h00);
    wait_idle();
  endtask

  // Drop a first byte that carries an unknown kind.
  task automatic test_unknown_kind();
    send_byte(4'd9, 8'hA5);
    send_byte(4'd15, 8'hFF);
    wait_idle();
  endtask

  // Change the kind in the middle of a field. The active field must keep its kind.
  task automatic test_kind_change_mid_field();
    send_byte(KIND_U32LE, 8'hFF);
    send_byte(4'd15, 8'hFF);
    send_byte(KIND_U1, 8'hFF);
    send_byte(KIND_S64LEB, 8'hFF);
    wait_idle();
  endtask

  // Cut LEB fields off at their byte limits, with the sign bit set in the last byte.
  task automatic test_leb_overlong();
    repeat (5) send_byte(KIND_S32LEB, 8'hFF);
    repeat (10) send_byte(KIND_S64LEB, 8'hFF);
    wait_idle();
  endtask

  // Use random fields with sender gaps and a random receiver stall.
  task automatic test_random_traffic(input int n);
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    send_mixed(n);
    wait_idle();
  endtask

  // Stream at full rate into a receiver with no stalls.
  task automatic test_full_rate(input int n);
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    send_mixed(n);
    wait_idle();
  endtask

  // Run bursty traffic on both sides.
  task automatic test_bursty_receiver(input int n);
    gaps_on = 1'b1;
    rx_mode = RX_BURSTY;
    send_mixed(n);
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering bytes.
  // This fills the pipeline and forces the input stall.
  task automatic test_backpressure(input int n);
    gaps_on    = 1'b0;
    rx_mode    = RX_RANDOM;
    hold_start = 300;
    send_mixed(n);
    wait_idle();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_single_byte_kinds();
    test_unknown_kind();
    test_kind_change_mid_field();
    test_leb_overlong();
    test_random_traffic(800);
    test_backpressure(250);
    test_full_rate(400);
    test_bursty_receiver(550);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run well after the slowest correct run would have finished.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
